[hw/rtl/tasf_pkg.sv]
// Package for the three-axis converter scan sequencer with frame queue.
// Holds opcode, phase and register index codes, reset values and port widths.
// No dependencies.
`timescale 1ns / 1ps

package tasf_pkg;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_TRIGGER = 2'd1,
        OP_CONV    = 2'd2,
        OP_READ    = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_CONV = 3'b010,
        PH_DONE = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        REG_CH_AXIS0 = 2'd0,
        REG_CH_AXIS1 = 2'd1,
        REG_CH_AXIS2 = 2'd2
    } t_reg_index;

    localparam int unsigned CH_W       = 5;
    localparam int unsigned AXIS_W     = 2;
    localparam int unsigned OUT_SMP_W  = 16;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 64;

    localparam logic [CH_W-1:0]   CH_AXIS0_RST = 5'd0;
    localparam logic [CH_W-1:0]   CH_AXIS1_RST = 5'd1;
    localparam logic [CH_W-1:0]   CH_AXIS2_RST = 5'd2;
    localparam logic [AXIS_W-1:0] AXIS_FIRST   = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_SECOND  = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_THIRD   = 2'd2;

    // Step outcome carried from the accept stage to the output register
    typedef struct packed {
        logic            start;
        logic [CH_W-1:0] chan;
        logic            frame_valid;
        logic            avail;
        logic            idle;
        logic            ovf;
    } t_step_info;

endpackage

[hw/rtl/tasf_ring_ram.sv]
// Frame ring storage: simple dual-port synchronous memory, registered read.
// Uses no package; depth and width come from the instantiating top level.
`timescale 1ns / 1ps

module tasf_ring_ram #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned WIDTH  = 48,
    parameter int unsigned ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/three_axis_adc_scan_fifo_core.sv]
// Three-axis converter scan sequencer with a frame ring (DEPTH-1 usable entries).
// Depends on tasf_pkg and tasf_ring_ram.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: opcode; tdata: conversion_value
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: one result per input transaction
// cfg       in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data (always ready)
//
// One input transaction per cycle while the output is not stalled; its result passes
// through the accept stage (with the ring read) and then the output register.
// Reset (i_rst_n low, synchronous) empties the ring, idles the sequencer and loads
// the default channels; no clearing pass, ring contents are only read after writes.
// A stalled output holds the accept stage, and s_axis_tready drops only when both the
// accept stage and the output register are full.
`timescale 1ns / 1ps

module three_axis_adc_scan_fifo_core #(
    parameter int unsigned DEPTH       = 64,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [tasf_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [15:0] conversion_value
    input  logic [1:0]                         s_axis_tuser,  // [1:0] opcode
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] start_conversion, [5:1] start_channel, [6] frame_valid,
    // [22:7] sample_first, [38:23] sample_second, [54:39] sample_third,
    // [55] frames_available, [56] sequencer_idle, [57] overflow, [63:58] zero
    output logic [tasf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [tasf_pkg::CH_W-1:0]          i_cfg_data
);

    localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned FRAME_W = 3 * SAMPLE_BITS;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    // configuration
    logic [tasf_pkg::CH_W-1:0] r_ch0, r_ch1, r_ch2;
    logic                      cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch0 <= tasf_pkg::CH_AXIS0_RST;
            r_ch1 <= tasf_pkg::CH_AXIS1_RST;
            r_ch2 <= tasf_pkg::CH_AXIS2_RST;
        end else if (cfg_we) begin
            case (tasf_pkg::t_reg_index'(i_cfg_index))
                tasf_pkg::REG_CH_AXIS0: r_ch0 <= i_cfg_data;
                tasf_pkg::REG_CH_AXIS1: r_ch1 <= i_cfg_data;
                tasf_pkg::REG_CH_AXIS2: r_ch2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and pointer state
    tasf_pkg::t_phase                r_phase, n_phase;
    logic [tasf_pkg::AXIS_W-1:0]     r_axis, n_axis;
    logic [SAMPLE_BITS-1:0]          r_asm0, n_asm0, r_asm1, n_asm1;
    logic [PTR_W-1:0]                r_wp, n_wp, r_rp, n_rp;
    logic [PTR_W-1:0]                wp_inc, rp_inc;
    logic [SAMPLE_BITS-1:0]          smp;
    tasf_pkg::t_step_info            step;

    logic                 ram_we, ram_re;
    logic [FRAME_W-1:0]   ram_wdata, ram_rdata;

    // pipeline control
    logic                    accept;
    logic                    r_s1_v;
    tasf_pkg::t_step_info    r_s1;
    logic                    s1_go;
    logic                    r_o_v;
    logic [tasf_pkg::OUT_DATA_W-1:0] r_o_data, n_o_data;

    assign s1_go         = r_s1_v & (~r_o_v | m_axis_tready);
    assign s_axis_tready = ~r_s1_v | s1_go;
    assign accept        = s_axis_tvalid & s_axis_tready;

    assign smp    = s_axis_tdata[SAMPLE_BITS-1:0];
    assign wp_inc = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
    assign rp_inc = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
    assign ram_wdata = {smp, r_asm1, r_asm0};

    always_comb begin
        n_phase = r_phase;
        n_axis  = r_axis;
        n_asm0  = r_asm0;
        n_asm1  = r_asm1;
        n_wp    = r_wp;
        n_rp    = r_rp;
        ram_we  = 1'b0;
        ram_re  = 1'b0;
        step    = '0;
        case (tasf_pkg::t_opcode'(s_axis_tuser))
            tasf_pkg::OP_TICK: begin
                if (r_phase == tasf_pkg::PH_DONE) begin
                    if (r_axis != tasf_pkg::AXIS_FIRST) begin
                        step.start = 1'b1;
                        step.chan  = (r_axis == tasf_pkg::AXIS_SECOND) ? r_ch1 : r_ch2;
                        n_phase    = tasf_pkg::PH_CONV;
                    end else begin
                        n_phase = tasf_pkg::PH_IDLE;
                    end
                end
            end
            tasf_pkg::OP_TRIGGER: begin
                if (r_phase == tasf_pkg::PH_IDLE) begin
                    n_axis     = tasf_pkg::AXIS_FIRST;
                    step.start = 1'b1;
                    step.chan  = r_ch0;
                    n_phase    = tasf_pkg::PH_CONV;
                end
            end
            tasf_pkg::OP_CONV: begin
                if (r_phase == tasf_pkg::PH_CONV) begin
                    n_phase = tasf_pkg::PH_DONE;
                    case (r_axis)
                        tasf_pkg::AXIS_FIRST: begin
                            n_asm0 = smp;
                            n_axis = tasf_pkg::AXIS_SECOND;
                        end
                        tasf_pkg::AXIS_SECOND: begin
                            n_asm1 = smp;
                            n_axis = tasf_pkg::AXIS_THIRD;
                        end
                        default: begin
                            n_axis = tasf_pkg::AXIS_FIRST;
                            if (wp_inc == r_rp) begin
                                step.ovf = 1'b1;
                            end else begin
                                ram_we = 1'b1;
                                n_wp   = wp_inc;
                            end
                        end
                    endcase
                end
            end
            default: begin
                if (r_rp != r_wp) begin
                    step.frame_valid = 1'b1;
                    ram_re           = 1'b1;
                    n_rp             = rp_inc;
                end
            end
        endcase
        step.avail = (n_rp != n_wp);
        step.idle  = (n_phase == tasf_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tasf_pkg::PH_IDLE;
            r_axis  <= tasf_pkg::AXIS_FIRST;
            r_asm0  <= '0;
            r_asm1  <= '0;
            r_wp    <= '0;
            r_rp    <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_axis  <= n_axis;
            r_asm0  <= n_asm0;
            r_asm1  <= n_asm1;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
        end
    end

    tasf_ring_ram #(
        .DEPTH  (DEPTH),
        .WIDTH  (FRAME_W),
        .ADDR_W (PTR_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (accept & ram_we),
        .i_waddr (r_wp),
        .i_wdata (ram_wdata),
        .i_re    (accept & ram_re),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    // accept stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (accept) begin
            r_s1_v <= 1'b1;
        end else if (s1_go) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= step;
        end
    end

    // output register
    always_comb begin
        n_o_data        = '0;
        n_o_data[0]     = r_s1.start;
        n_o_data[5:1]   = r_s1.chan;
        n_o_data[6]     = r_s1.frame_valid;
        if (r_s1.frame_valid) begin
            n_o_data[22:7]  = tasf_pkg::OUT_SMP_W'(ram_rdata[SAMPLE_BITS-1:0]);
            n_o_data[38:23] = tasf_pkg::OUT_SMP_W'(ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
            n_o_data[54:39] = tasf_pkg::OUT_SMP_W'(ram_rdata[FRAME_W-1:2*SAMPLE_BITS]);
        end
        n_o_data[55]    = r_s1.avail;
        n_o_data[56]    = r_s1.idle;
        n_o_data[57]    = r_s1.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s1_go) begin
            r_o_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_o_data <= n_o_data;
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = r_o_data;

    // checks
    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ram_we) |-> (wp_inc != r_rp))
        else $error("ring written while full");

    a_no_read_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ram_re) |-> (r_rp != r_wp))
        else $error("ring read while empty");

    a_rdata_held_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !s1_go) |=> $stable(ram_rdata))
        else $error("ring read data changed under a stalled result");

    a_ovf_excludes_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v |-> !(r_s1.ovf && r_s1.frame_valid))
        else $error("overflow and popped frame in one step");

endmodule
